### hw/rtl/rank_tracking_priority_queue_top_defines.svh
// assertion macros for the rank tracking priority queue
`ifndef RANK_TRACKING_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define RANK_TRACKING_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RTPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define RTPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rtpq_pkg.sv
// shared types and constants of the rank tracking priority queue
`timescale 1ns / 1ps

package rtpq_pkg;

  // parameter defaults
  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int unsigned TARGET_W    = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned RANK_OUT_W  = 4;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned DATA_W      = 32;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the accepted input item
    logic comp;   // run the per-entry compares
    logic upd;    // commit entry updates and the result
  } ctrl_cmd_t;

endpackage

### hw/rtl/rtpq_ctrl.sv
// controller state machine of the rank tracking priority queue
`timescale 1ns / 1ps

module rtpq_ctrl import rtpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COMP = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  // output slot can take a result this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // a new item may enter while the previous one commits
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_UPD) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_COMP;
      end
      S_COMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) state_d = accept ? S_COMP : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o.load = accept;
    cmd_o.comp = (state_q == S_COMP);
    cmd_o.upd  = (state_q == S_UPD) && out_free;
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.upd) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/rtpq_datapath.sv
// entry store, per-entry compare and update, and result register
`timescale 1ns / 1ps

module rtpq_datapath import rtpq_pkg::*; #(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  input  logic                     opcode_i,
  input  logic signed [DATA_W-1:0] new_value_i,
  input  logic [TARGET_W-1:0]      target_rank_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [RANK_OUT_W-1:0]    rank_out_o,
  output logic signed [DATA_W-1:0] removed_value_o,
  output logic [COUNT_OUT_W-1:0]   entry_count_o
);

  localparam int unsigned RW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (RW > TARGET_W) ? RW : TARGET_W;
  localparam int unsigned NP   = 1 << RW;

  // captured input item
  logic                          op_q;
  logic signed [VALUE_WIDTH-1:0] nv_q;
  logic [TARGET_W-1:0]           tgt_q;

  // entry store
  logic signed [VALUE_WIDTH-1:0] val_q  [DEPTH];
  logic [RW-1:0]                 rank_q [DEPTH];
  logic [DEPTH-1:0]              valid_q;
  logic [CW-1:0]                 count_q, count_d;

  // compare stage
  logic [DEPTH-1:0] ge_q, ge_d;
  logic [DEPTH-1:0] hit_q, hit_d;
  logic [DEPTH-1:0] gt_q, gt_d;
  logic [DEPTH-1:0] slot_q, slot_d;
  logic [DEPTH-1:0] free;
  logic             full_q, full_d;

  // update stage
  logic [CW-1:0]                 pc [RW+1][NP];
  logic [RW-1:0]                 rank_new;
  logic                          any_hit;
  logic                          ins_ok;
  logic                          rem_ok;
  logic signed [VALUE_WIDTH-1:0] sel_val;
  logic [STATUS_W-1:0]           status_d;
  logic [RANK_OUT_W-1:0]         rank_out_d;
  logic signed [DATA_W-1:0]      removed_d;

  // result register
  logic [STATUS_W-1:0]      status_q;
  logic [RANK_OUT_W-1:0]    rank_out_q;
  logic signed [DATA_W-1:0] removed_q;
  logic [COUNT_OUT_W-1:0]   count_out_q;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      nv_q  <= VALUE_WIDTH'($unsigned(new_value_i));
      tgt_q <= target_rank_i;
    end
  end

  // per-entry compares and lowest free slot
  assign free   = ~valid_q;
  assign slot_d = free & (~free + DEPTH'(1));
  assign full_d = (count_q == CW'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge_d[i]  = valid_q[i] && (val_q[i] >= nv_q);
      hit_d[i] = valid_q[i] && (CMPW'(rank_q[i]) == CMPW'(tgt_q));
      gt_d[i]  = valid_q[i] && (CMPW'(rank_q[i]) > CMPW'(tgt_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.comp) begin
      ge_q   <= ge_d;
      hit_q  <= hit_d;
      gt_q   <= gt_d;
      slot_q <= slot_d;
      full_q <= full_d;
    end
  end

  // adder tree counting entries greater than or equal to the new value
  always_comb begin
    for (int l = 0; l <= RW; l++) begin
      for (int j = 0; j < NP; j++) begin
        pc[l][j] = '0;
      end
    end
    for (int j = 0; j < DEPTH; j++) begin
      pc[0][j] = CW'(ge_q[j]);
    end
    for (int l = 1; l <= RW; l++) begin
      for (int j = 0; j < (NP >> l); j++) begin
        pc[l][j] = pc[l-1][2*j] + pc[l-1][2*j+1];
      end
    end
  end

  assign rank_new = RW'(pc[RW][0]);

  // select the value of the entry being removed
  always_comb begin
    sel_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_val = sel_val | (val_q[i] & {VALUE_WIDTH{hit_q[i]}});
    end
  end

  assign any_hit = |hit_q;
  assign ins_ok  = (op_q == OP_INSERT) && !full_q;
  assign rem_ok  = (op_q == OP_REMOVE) && any_hit;

  // result and new count
  always_comb begin
    status_d   = ST_INSERTED;
    rank_out_d = '0;
    removed_d  = '0;
    count_d    = count_q;
    if (op_q == OP_INSERT) begin
      if (full_q) begin
        status_d = ST_FULL;
      end else begin
        status_d   = ST_INSERTED;
        rank_out_d = RANK_OUT_W'(rank_new);
        count_d    = count_q + CW'(1);
      end
    end else begin
      rank_out_d = tgt_q;
      if (any_hit) begin
        status_d  = ST_REMOVED;
        removed_d = DATA_W'(sel_val);
        count_d   = count_q - CW'(1);
      end else begin
        status_d = ST_NOT_FOUND;
      end
    end
  end

  // entry values and ranks
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.upd) begin
        if (ins_ok) begin
          if (slot_q[i]) begin
            val_q[i]  <= nv_q;
            rank_q[i] <= rank_new;
          end else if (valid_q[i] && !ge_q[i]) begin
            rank_q[i] <= rank_q[i] + RW'(1);
          end
        end else if (rem_ok && gt_q[i]) begin
          rank_q[i] <= rank_q[i] - RW'(1);
        end
      end
    end
  end

  // valid bits and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.upd) begin
      if (ins_ok) begin
        valid_q <= valid_q | slot_q;
      end else if (rem_ok) begin
        valid_q <= valid_q & ~hit_q;
      end
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      status_q    <= status_d;
      rank_out_q  <= rank_out_d;
      removed_q   <= removed_d;
      count_out_q <= COUNT_OUT_W'(count_d);
    end
  end

  assign status_o        = status_q;
  assign rank_out_o      = rank_out_q;
  assign removed_value_o = removed_q;
  assign entry_count_o   = count_out_q;

endmodule

### hw/rtl/rank_tracking_priority_queue_top.sv
// Rank tracking priority queue, top level.
//
// Stores up to DEPTH signed values; rank 0 is the largest. An input item
// (opcode, new_value, target_rank) either inserts new_value or removes the
// entry holding target_rank. Each item gives exactly one result item
// (status, rank_out, removed_value, entry_count).
// Both channels are valid/ready; an item moves when valid and ready are high.
// An accepted item is captured, compared per entry into the compare
// register, then committed into the result register. A new item is taken
// in the commit cycle of the previous one, so no item enters while one is
// in its compare step; the rank adder tree lies between the compare
// register and the commit.
// The result sits in an output register. While the receiver stalls, the
// commit of the next item waits and input ready drops until the register
// frees up.
// Reset clears the valid bits and the count; the store is empty at once.
`timescale 1ns / 1ps
`include "rank_tracking_priority_queue_top_defines.svh"

module rank_tracking_priority_queue_top import rtpq_pkg::*; #(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     opcode_i,
  input  logic signed [DATA_W-1:0] new_value_i,
  input  logic [TARGET_W-1:0]      target_rank_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [RANK_OUT_W-1:0]    rank_out_o,
  output logic signed [DATA_W-1:0] removed_value_o,
  output logic [COUNT_OUT_W-1:0]   entry_count_o
);

  ctrl_cmd_t cmd;

  // controller
  rtpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath
  rtpq_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .opcode_i        (opcode_i),
    .new_value_i     (new_value_i),
    .target_rank_i   (target_rank_i),
    .status_o        (status_o),
    .rank_out_o      (rank_out_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o)
  );

  // checks
  `RTPQ_ASSERT_NXT(a_no_back_to_back_accept, in_valid_i && in_ready_o, !in_ready_o,
                   "accepted item while compare pending")
  `RTPQ_ASSERT_IMP(a_result_follows, in_valid_i && in_ready_o, ##3 out_valid_o,
                   "no result three cycles after item")
  `RTPQ_ASSERT_IMP(a_removed_zero, out_valid_o && (status_o != ST_REMOVED),
                   removed_value_o == '0, "removed value set without remove")
  `RTPQ_ASSERT_IMP(a_full_rank_zero, out_valid_o && (status_o == ST_FULL),
                   rank_out_o == '0, "rank given on full store")

endmodule

### dv/tb_top.sv
// testbench for the rank tracking priority queue: directed table, random mix, scoreboard
`timescale 1ns / 1ps

module tb_top import rtpq_pkg::*; ();

  localparam int unsigned QDEPTH     = DEPTH_DEF;
  localparam int          RAND_ITEMS = 900;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          HOLD_CYC   = 80;
  localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [RANK_OUT_W-1:0]    rank;
    logic signed [DATA_W-1:0] removed;
    logic [COUNT_OUT_W-1:0]   count;
  } result_t;

  // one stimulus row; typed rows carry their own expected result
  typedef struct {
    logic                     op;
    logic signed [DATA_W-1:0] value;
    logic [TARGET_W-1:0]      target;
    bit                       typed;
    result_t                  res;
  } stim_row_t;

  typedef struct {
    bit      typed;
    result_t res;
  } row_tag_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     opcode_i;
  logic signed [DATA_W-1:0] new_value_i;
  logic [TARGET_W-1:0]      target_rank_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [STATUS_W-1:0]      status_o;
  logic [RANK_OUT_W-1:0]    rank_out_o;
  logic signed [DATA_W-1:0] removed_value_o;
  logic [COUNT_OUT_W-1:0]   entry_count_o;

  // shadow copy of the store
  logic signed [DATA_W-1:0] shadow_value [QDEPTH];
  int                       shadow_rank  [QDEPTH];
  bit                       shadow_used  [QDEPTH];
  int                       shadow_count;

  stim_row_t directed_rows[$];
  row_tag_t  offered_tags[$];
  result_t   expected_results[$];
  int        mismatch_count;
  bit        tx_calm;
  bit        rx_calm;
  bit        rx_hold_req;

  rank_tracking_priority_queue_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .new_value_i     (new_value_i),
    .target_rank_i   (target_rank_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .rank_out_o      (rank_out_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // apply one operation to the shadow store and return its result
  function automatic result_t apply_queue_op(input logic op, input logic signed [DATA_W-1:0] val,
                                             input logic [TARGET_W-1:0] target);
    result_t r;
    int      place;
    int      free_slot;
    int      hit;
    r = '0;
    if (op == OP_INSERT) begin
      if (shadow_count >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        place     = 0;
        free_slot = -1;
        for (int i = 0; i < QDEPTH; i++) begin
          if (shadow_used[i]) begin
            // smaller values move down, equal or greater ones stay ahead
            if (val > shadow_value[i]) shadow_rank[i]++;
            else place++;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        shadow_value[free_slot] = val;
        shadow_rank[free_slot]  = place;
        shadow_used[free_slot]  = 1'b1;
        shadow_count++;
        r.status = ST_INSERTED;
        r.rank   = place[RANK_OUT_W-1:0];
      end
    end else begin
      r.rank = target;
      hit    = -1;
      for (int i = 0; i < QDEPTH; i++) begin
        if (shadow_used[i] && shadow_rank[i] == int'(target) && hit < 0) hit = i;
      end
      if (hit >= 0) begin
        r.removed         = shadow_value[hit];
        shadow_used[hit] = 1'b0;
        for (int i = 0; i < QDEPTH; i++) begin
          if (shadow_used[i] && shadow_rank[i] > int'(target)) shadow_rank[i]--;
        end
        shadow_count--;
        r.status = ST_REMOVED;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    r.count = shadow_count[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // table entry
  task automatic add_row(input logic op, input logic signed [DATA_W-1:0] val,
                         input logic [TARGET_W-1:0] target, input bit typed,
                         input logic [STATUS_W-1:0] st, input logic [RANK_OUT_W-1:0] rk,
                         input logic signed [DATA_W-1:0] rv, input logic [COUNT_OUT_W-1:0] cnt);
    stim_row_t row;
    row.op     = op;
    row.value  = val;
    row.target = target;
    row.typed  = typed;
    row.res    = '{status: st, rank: rk, removed: rv, count: cnt};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // offer one item and hold it until accepted
  task automatic send_item(input logic op, input logic signed [DATA_W-1:0] val,
                           input logic [TARGET_W-1:0] target, input bit typed,
                           input result_t res);
    int       gap;
    row_tag_t tag;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    new_value_i   <= val;
    target_rank_i <= target;
    tag.typed = typed;
    tag.res   = res;
    offered_tags.insert(offered_tags.size(), tag);
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // random value: full range, a narrow band for ties, or an extreme
  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 3);
    case (sel)
      0: begin
        return $urandom_range(0, 8) - 4;
      end
      1: begin
        case ($urandom_range(0, 4))
          0: return VMAX;
          1: return VMIN;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    int      insert_pct;
    int      idle_cycles;
    logic    op;
    logic [TARGET_W-1:0] target;
    result_t none;

    in_valid_i    = 1'b0;
    opcode_i      = OP_INSERT;
    new_value_i   = '0;
    target_rank_i = '0;
    tx_calm       = 1'b0;
    rx_hold_req   = 1'b0;
    none          = '0;

    // empty store, extremes, ties, full store, absent ranks
    add_row(OP_REMOVE, 32'sh1234_5678, 4'd0,  1, ST_NOT_FOUND, 4'd0,  '0,   5'd0);
    add_row(OP_REMOVE, VMIN,           4'd15, 1, ST_NOT_FOUND, 4'd15, '0,   5'd0);
    add_row(OP_INSERT, VMAX,           4'd9,  1, ST_INSERTED,  4'd0,  '0,   5'd1);
    add_row(OP_INSERT, VMIN,           4'd15, 1, ST_INSERTED,  4'd1,  '0,   5'd2);
    add_row(OP_INSERT, 32'sd0,         4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, -32'sd1,        4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, 32'sd0,         4'd0,  0, '0, '0, '0, '0);
    add_row(OP_REMOVE, 32'sd0,         4'd0,  1, ST_REMOVED,   4'd0,  VMAX, 5'd4);
    add_row(OP_INSERT, 32'sd1,         4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, 32'sd2,         4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, -32'sd2,        4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, 32'sd100,       4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, -32'sd100,      4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, 32'sd0,         4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, 32'sd0,         4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, 32'sd5,         4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, 32'sh4000_0000, 4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, 32'shC000_0000, 4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, 32'sd7,         4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, -32'sd7,        4'd0,  0, '0, '0, '0, '0);
    add_row(OP_INSERT, 32'sd123,       4'd0,  1, ST_FULL,      4'd0,  '0,   5'd16);
    add_row(OP_REMOVE, 32'sd0,         4'd15, 0, '0, '0, '0, '0);
    add_row(OP_REMOVE, 32'sd0,         4'd15, 1, ST_NOT_FOUND, 4'd15, '0,   5'd15);
    add_row(OP_REMOVE, 32'sd0,         4'd7,  0, '0, '0, '0, '0);

    @(posedge rst_ni);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].target,
                directed_rows[i].typed, directed_rows[i].res);
    end

    // random mix; the insert share drifts so the store both fills and drains
    insert_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 25;
          1: insert_pct = 50;
          2: insert_pct = 75;
          default: insert_pct = 90;
        endcase
      end
      if (n % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      // long receiver hold-off while items keep coming
      if (n == 250 || n == 700) rx_hold_req = 1'b1;
      // drain everything before going on
      if (n == 450) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_results.size() != 0);
      end
      op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
      if (op == OP_REMOVE && shadow_count > 0 && $urandom_range(0, 99) < 85) begin
        target = TARGET_W'($urandom_range(0, shadow_count - 1));
      end else begin
        target = TARGET_W'($urandom_range(0, 15));
      end
      send_item(op, pick_value(), target, 1'b0, none);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // wait out the remaining results
    do @(posedge clk_i); while (expected_results.size() != 0);
    idle_cycles = 10;
    repeat (idle_cycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver side with random stalls and a long hold-off on each request
  initial begin : receiver
    int stall;
    int taken;
    out_ready_i = 1'b0;
    rx_calm     = 1'b0;
    taken       = 0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        repeat (HOLD_CYC) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
      end
      if (taken % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      taken++;
    end
  end

  // scoreboard: predict on accepted input items, compare accepted results
  always @(posedge clk_i) begin : scoreboard
    row_tag_t tag;
    result_t  predicted;
    result_t  want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tag       = offered_tags.pop_front();
        predicted = apply_queue_op(opcode_i, new_value_i, target_rank_i);
        expected_results.insert(expected_results.size(), tag.typed ? tag.res : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: status %0d rank %0d", status_o, rank_out_o);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatch_count++;
          end
          if (rank_out_o !== want.rank) begin
            $error("rank_out: expected %0d, got %0d", want.rank, rank_out_o);
            mismatch_count++;
          end
          if (removed_value_o !== want.removed) begin
            $error("removed_value: expected %0d, got %0d", want.removed, removed_value_o);
            mismatch_count++;
          end
          if (entry_count_o !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // empty shadow store at reset
  initial begin
    mismatch_count = 0;
    shadow_count   = 0;
    for (int i = 0; i < QDEPTH; i++) begin
      shadow_value[i] = '0;
      shadow_rank[i]  = 0;
      shadow_used[i]  = 1'b0;
    end
  end

endmodule
